@@ rtl/gtc_pkg.sv @@
// ----------------------------------------------------------------------------
// Generic timer compare package
// Shared codes, widths and pipeline types for the timer compare block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtc_pkg;

  localparam int CountW = 64;
  localparam int TickW  = 32;
  localparam int SelW   = 3;
  localparam int CtlW   = 2;

  localparam int InDataW  = 104;  // 101 payload bits filled up to whole bytes
  localparam int OutDataW = 136;  // 131 payload bits filled up to whole bytes

  localparam logic [CountW-1:0] AllOnes = '1;

  // Control register bits.
  localparam int CtlEnableBit = 0;
  localparam int CtlMaskBit   = 1;

  typedef enum logic [1:0] {
    ACT_ADVANCE = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_READ    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [SelW-1:0] {
    SEL_PHYS_CTL   = 3'd0,
    SEL_PHYS_CMP   = 3'd1,
    SEL_VIRT_CTL   = 3'd2,
    SEL_VIRT_CMP   = 3'd3,
    SEL_PHYS_COUNT = 3'd4,
    SEL_VIRT_COUNT = 3'd5,
    SEL_SPARE6     = 3'd6,
    SEL_SPARE7     = 3'd7
  } reg_sel_t;

  // Timer state as it stands right after one request took effect.
  typedef struct packed {
    logic [CountW-1:0] phys_count;
    logic [CountW-1:0] virt_count;
    logic [CtlW-1:0]   phys_ctl;
    logic [CountW-1:0] phys_cmp;
    logic [CtlW-1:0]   virt_ctl;
    logic [CountW-1:0] virt_cmp;
    logic [CountW-1:0] read_value;
  } snapshot_t;

  // Finished result of one request.
  typedef struct packed {
    logic              phys_irq;
    logic              virt_irq;
    logic [CountW-1:0] ticks_to_deadline;
    logic              none_armed;
    logic [CountW-1:0] read_value;
  } result_t;

  function automatic logic is_armed(input logic [CtlW-1:0] ctl);
    return ctl[CtlEnableBit] & ~ctl[CtlMaskBit];
  endfunction

endpackage : gtc_pkg

`default_nettype wire

@@ rtl/gtc_deadline.sv @@
// ----------------------------------------------------------------------------
// Generic timer compare deadline pipeline
// Two stages: per-timer due test and distance, then the nearest deadline.
// ----------------------------------------------------------------------------
`default_nettype none

module gtc_deadline (
  input  wire               clk,
  input  wire               rst,
  input  wire               advance,
  input  wire               snap_valid,
  input  wire gtc_pkg::snapshot_t snap,
  output logic              res_valid,
  output gtc_pkg::result_t  res
);
  import gtc_pkg::*;

  typedef struct packed {
    logic              phys_irq;
    logic              virt_irq;
    logic              none_armed;
    logic [CountW-1:0] phys_dist;
    logic [CountW-1:0] virt_dist;
    logic [CountW-1:0] read_value;
  } dist_t;

  logic [CountW:0]   phys_diff;
  logic [CountW:0]   virt_diff;
  logic              phys_due;
  logic              virt_due;
  logic              phys_arm;
  logic              virt_arm;
  dist_t             dist_next;
  dist_t             distance;
  logic              dist_valid;
  result_t           res_next;

  // A borrow or a zero difference means the count has reached the compare.
  always_comb begin
    phys_diff = {1'b0, snap.phys_cmp} - {1'b0, snap.phys_count};
    virt_diff = {1'b0, snap.virt_cmp} - {1'b0, snap.virt_count};
    phys_due  = phys_diff[CountW] | (phys_diff[CountW-1:0] == '0);
    virt_due  = virt_diff[CountW] | (virt_diff[CountW-1:0] == '0);
    phys_arm  = is_armed(snap.phys_ctl);
    virt_arm  = is_armed(snap.virt_ctl);

    dist_next.phys_irq   = phys_arm & phys_due;
    dist_next.virt_irq   = virt_arm & virt_due;
    dist_next.none_armed = ~phys_arm & ~virt_arm;
    dist_next.phys_dist  = !phys_arm ? AllOnes :
                           (phys_due ? '0 : phys_diff[CountW-1:0]);
    dist_next.virt_dist  = !virt_arm ? AllOnes :
                           (virt_due ? '0 : virt_diff[CountW-1:0]);
    dist_next.read_value = snap.read_value;
  end

  always_comb begin
    res_next.phys_irq          = distance.phys_irq;
    res_next.virt_irq          = distance.virt_irq;
    res_next.none_armed        = distance.none_armed;
    res_next.read_value        = distance.read_value;
    res_next.ticks_to_deadline = (distance.virt_dist < distance.phys_dist) ?
                                 distance.virt_dist : distance.phys_dist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else if (advance) begin
      dist_valid <= snap_valid;
      res_valid  <= dist_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      distance <= dist_next;
      res      <= res_next;
    end
  end

endmodule : gtc_deadline

`default_nettype wire

@@ rtl/generic_timer_compare.sv @@
// ----------------------------------------------------------------------------
// Generic timer compare
// 64-bit physical count with physical and virtual compare timers.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: each one advances the count, writes a
// timer register or reads a register. Every request yields exactly one result
// on the m_axis channel carrying both interrupt lines, the ticks until the
// nearest armed deadline (all ones with none_armed set when no timer is armed)
// and the read data (zero unless the request was a read).
// The user must load the virtual offset through cfg_we/cfg_data only while the
// block is idle; the block does not enforce this. The virtual count is kept in
// its own register and rebuilt on that write. Timer state is updated at the
// edge that accepts a request, and a snapshot of the updated state enters a
// three-stage pipeline: snapshot, per-timer distance and due test, then the
// nearest-deadline select into the output register that drives m_axis_tvalid.
// One request is accepted every cycle as long as the output register is empty
// or being drained. When the receiver holds m_axis_tready low with a result
// waiting, the whole pipeline holds and s_axis_tready falls in the same cycle.
// Reset clears the count, the virtual count, both control and compare
// registers and all pipeline valid bits; no result is pending afterward.
// ----------------------------------------------------------------------------
`default_nettype none

module generic_timer_compare (
  input  wire                            clk,
  input  wire                            rst,
  // Configuration: virtual offset.
  input  wire                            cfg_we,
  input  wire  [gtc_pkg::CountW-1:0]     cfg_data,
  // Requests. tdata from bit 0: action[1:0], tick_amount[33:2],
  // reg_select[36:34], write_value[100:37], zero fill [103:101].
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire  [gtc_pkg::InDataW-1:0]    s_axis_tdata,
  // Results. tdata from bit 0: phys_irq[0], virt_irq[1],
  // ticks_to_deadline[65:2], none_armed[66], read_value[130:67],
  // zero fill [135:131].
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic [gtc_pkg::OutDataW-1:0]   m_axis_tdata
);
  import gtc_pkg::*;

  // Request fields.
  action_t           in_action;
  logic [TickW-1:0]  in_ticks;
  reg_sel_t          in_sel;
  logic [CountW-1:0] in_wval;

  assign in_action = action_t'(s_axis_tdata[1:0]);
  assign in_ticks  = s_axis_tdata[33:2];
  assign in_sel    = reg_sel_t'(s_axis_tdata[36:34]);
  assign in_wval   = s_axis_tdata[100:37];

  // Architectural state.
  logic [CountW-1:0] physical_count;
  logic [CountW-1:0] virtual_count;
  logic [CtlW-1:0]   phys_control;
  logic [CountW-1:0] phys_compare;
  logic [CtlW-1:0]   virt_control;
  logic [CountW-1:0] virt_compare;

  logic [CountW-1:0] physical_count_next;
  logic [CountW-1:0] virtual_count_next;
  logic [CtlW-1:0]   phys_control_next;
  logic [CountW-1:0] phys_compare_next;
  logic [CtlW-1:0]   virt_control_next;
  logic [CountW-1:0] virt_compare_next;
  logic [CountW-1:0] read_mux;

  logic              advance;
  logic              accept;
  snapshot_t         snap_next;
  snapshot_t         snap;
  logic              snap_valid;
  logic              res_valid;
  result_t           res;

  // The pipeline moves whenever the output register can take a new value.
  assign advance       = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid & advance;

  // Reads see the state before the request, which a read never changes.
  always_comb begin
    unique case (in_sel)
      SEL_PHYS_CTL:   read_mux = {{(CountW-CtlW){1'b0}}, phys_control};
      SEL_PHYS_CMP:   read_mux = phys_compare;
      SEL_VIRT_CTL:   read_mux = {{(CountW-CtlW){1'b0}}, virt_control};
      SEL_VIRT_CMP:   read_mux = virt_compare;
      SEL_PHYS_COUNT: read_mux = physical_count;
      SEL_VIRT_COUNT: read_mux = virtual_count;
      default:        read_mux = '0;
    endcase
  end

  // Next state for one request. Both counts step by the same tick amount, so
  // the virtual count stays equal to physical count minus the offset.
  always_comb begin
    physical_count_next = physical_count;
    virtual_count_next  = virtual_count;
    phys_control_next   = phys_control;
    phys_compare_next   = phys_compare;
    virt_control_next   = virt_control;
    virt_compare_next   = virt_compare;
    case (in_action)
      ACT_ADVANCE: begin
        physical_count_next = physical_count + {{(CountW-TickW){1'b0}}, in_ticks};
        virtual_count_next  = virtual_count + {{(CountW-TickW){1'b0}}, in_ticks};
      end
      ACT_WRITE: begin
        // Count registers and the spare selects ignore writes.
        case (in_sel)
          SEL_PHYS_CTL: phys_control_next = in_wval[CtlW-1:0];
          SEL_PHYS_CMP: phys_compare_next = in_wval;
          SEL_VIRT_CTL: virt_control_next = in_wval[CtlW-1:0];
          SEL_VIRT_CMP: virt_compare_next = in_wval;
          default:      ;
        endcase
      end
      default: ;
    endcase

    snap_next.phys_count = physical_count_next;
    snap_next.virt_count = virtual_count_next;
    snap_next.phys_ctl   = phys_control_next;
    snap_next.phys_cmp   = phys_compare_next;
    snap_next.virt_ctl   = virt_control_next;
    snap_next.virt_cmp   = virt_compare_next;
    snap_next.read_value = (in_action == ACT_READ) ? read_mux : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      physical_count <= '0;
      virtual_count  <= '0;
      phys_control   <= '0;
      phys_compare   <= '0;
      virt_control   <= '0;
      virt_compare   <= '0;
    end else if (cfg_we) begin
      // Offset writes must come only while no request is in flight; nothing enforces it.
      virtual_count  <= physical_count - cfg_data;
    end else if (accept) begin
      physical_count <= physical_count_next;
      virtual_count  <= virtual_count_next;
      phys_control   <= phys_control_next;
      phys_compare   <= phys_compare_next;
      virt_control   <= virt_control_next;
      virt_compare   <= virt_compare_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (advance) begin
      snap_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      snap <= snap_next;
    end
  end

  gtc_deadline u_deadline (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .snap_valid (snap_valid),
    .snap       (snap),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {5'b0, res.read_value, res.none_armed,
                          res.ticks_to_deadline, res.virt_irq, res.phys_irq};

endmodule : generic_timer_compare

`default_nettype wire
